@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, codes and the FCS-16 digit step shared by the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CRC_W  = 16;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    // Receive phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_REV  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_ESC  = 3'd4;
    localparam logic [2:0] PH_FCSH = 3'd5;
    localparam logic [2:0] PH_FCSL = 3'd6;
    localparam logic [2:0] PH_END  = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_REVISION = 2'd0;
    localparam logic [1:0] CFG_HDR_SIZE = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd2;
    localparam logic [1:0] CFG_CRC_SEED = 2'd3;

    // Delivery request from the receive control to the packet buffer
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_dlv_req;

    // Advance the reflected FCS-16 over one 4-bit digit, low bit first.
    function automatic logic [CRC_W-1:0] fcs_nibble(input logic [CRC_W-1:0] crc,
                                                    input logic [3:0] nib);
        logic [CRC_W-1:0] c;
        c = crc ^ {12'd0, nib};
        for (int i = 0; i < 4; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/serial_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Serial-binding deframer: flag hunt, unescape, FCS-16 check, packet delivery.
// ----------------------------------------------------------------------------
// One received line byte enters per request on the slave stream. The block
// hunts for the 0x7E start flag, checks the revision and length bytes,
// unescapes and stores the data bytes, reads the FCS high byte first and, on
// a closing flag with a matching FCS, streams the packet out one byte per
// request with tlast on the final byte. A byte that feeds the FCS (revision,
// length, data) holds the input off while its high digit is folded in, since
// the FCS unit folds in one 4-bit digit per cycle; all other bytes need no such
// hold. While a packet is read out of the store the input is held off; readout
// moves one byte per cycle while the sink does not stall, through a registered
// memory read and an output register. The store needs no clearing pass after
// reset. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // line byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // packet stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] packet_byte, [14:8] packet_length
    output logic        o_m_axis_tlast    // last_byte
);

    localparam int unsigned ADDR_W = $clog2(MAX_PACKET);
    localparam int unsigned CNT_W  = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;
    localparam logic [7:0]  MAX_PKT_B = 8'(MAX_PACKET);

    // configuration registers
    logic [7:0]       r_rev_code;
    logic [5:0]       r_hdr_size;
    logic [LEN_W-1:0] r_max_len;
    logic [CRC_W-1:0] r_crc_seed;

    // receive control state
    logic [2:0]       r_phase, n_phase;
    logic [CRC_W-1:0] r_fcs, n_fcs;
    logic [LEN_W-1:0] r_exp_len, n_exp_len;
    logic [CNT_W-1:0] r_count, n_count;

    logic             acc;
    logic [7:0]       rx;
    logic [7:0]       unesc;
    logic [7:0]       limit;
    logic [CNT_W-1:0] count_inc;
    logic             store;
    logic [7:0]       store_data;
    logic             seed_ld;
    logic             crc_vld;
    logic [7:0]       crc_byte;
    logic [CRC_W-1:0] crc;
    logic             crc_busy;
    logic             dlv_active;
    t_dlv_req         dlv;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] out_len;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_code <= 8'd1;
            r_hdr_size <= 6'd4;
            r_max_len  <= LEN_W'(64);
            r_crc_seed <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REVISION: r_rev_code <= i_cfg_data[7:0];
                CFG_HDR_SIZE: r_hdr_size <= i_cfg_data[5:0];
                CFG_MAX_LEN:  r_max_len  <= i_cfg_data[LEN_W-1:0];
                CFG_CRC_SEED: r_crc_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Receive control
    // ------------------------------------------------------------------------
    // Hold the line side off while the FCS digit unit finishes a byte or a
    // packet is still being read out of the store.
    assign o_s_axis_tready = !crc_busy && !dlv_active;
    assign acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign rx    = i_s_axis_tdata;
    assign unesc = rx ^ ESC_XOR;

    // max_length beyond the store size acts as the store size
    assign limit = ({1'b0, r_max_len} > MAX_PKT_B) ? MAX_PKT_B : {1'b0, r_max_len};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_fcs      = r_fcs;
        n_exp_len  = r_exp_len;
        n_count    = r_count;
        store      = 1'b0;
        store_data = rx;
        seed_ld    = 1'b0;
        crc_vld    = 1'b0;
        crc_byte   = rx;
        dlv.start  = 1'b0;
        dlv.len    = r_exp_len;
        if (acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (rx == FLAG_BYTE) begin
                        seed_ld = 1'b1;
                        n_phase = PH_REV;
                    end
                end
                PH_REV: begin
                    // revision match wins over a repeated flag
                    if (rx == r_rev_code) begin
                        crc_vld = 1'b1;
                        n_phase = PH_LEN;
                    end else if (rx != FLAG_BYTE) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    if (rx > {2'b00, r_hdr_size} && rx <= limit) begin
                        crc_vld   = 1'b1;
                        n_exp_len = rx[LEN_W-1:0];
                        n_count   = '0;
                        n_phase   = PH_DATA;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (rx == ESC_BYTE) begin
                        n_phase = PH_ESC;
                    end else begin
                        store = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (unesc == ESC_BYTE || unesc == FLAG_BYTE) begin
                        store      = 1'b1;
                        store_data = unesc;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FCSH: begin
                    n_fcs   = {rx, r_fcs[7:0]};
                    n_phase = PH_FCSL;
                end
                PH_FCSL: begin
                    n_fcs   = {r_fcs[15:8], rx};
                    n_phase = PH_END;
                end
                PH_END: begin
                    // the closing flag never doubles as the next start flag
                    if (rx == FLAG_BYTE && crc == r_fcs) begin
                        dlv.start = 1'b1;
                    end
                    n_phase = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
            if (store) begin
                crc_vld  = 1'b1;
                crc_byte = store_data;
                n_count  = count_inc;
                n_phase  = (count_inc >= CNT_W'(r_exp_len)) ? PH_FCSH : PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_fcs     <= '0;
            r_exp_len <= '0;
            r_count   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_fcs     <= n_fcs;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
        end
    end

    // ------------------------------------------------------------------------
    // FCS digit unit and packet store
    // ------------------------------------------------------------------------
    sfr_crc_digit u_crc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed_ld  (seed_ld),
        .i_seed     (r_crc_seed),
        .i_byte_vld (crc_vld),
        .i_byte     (crc_byte),
        .o_crc      (crc),
        .o_busy     (crc_busy)
    );

    sfr_pkt_buffer #(
        .MAX_PACKET (MAX_PACKET)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (store),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (store_data),
        .i_dlv     (dlv),
        .o_active  (dlv_active),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_byte    (out_byte),
        .o_len     (out_len),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_len, out_byte};

endmodule

@@ rtl/sfr_crc_digit.sv @@
// ----------------------------------------------------------------------------
// sfr_crc_digit
// FCS-16 unit that folds in one byte as two 4-bit digits, low digit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_crc_digit
    import sfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seed_ld,
    input  logic [CRC_W-1:0] i_seed,
    input  logic             i_byte_vld,
    input  logic [7:0]       i_byte,
    output logic [CRC_W-1:0] o_crc,
    output logic             o_busy
);

    logic [CRC_W-1:0] r_crc, n_crc;
    logic [3:0]       r_hi, n_hi;
    logic             r_busy, n_busy;

    always_comb begin
        n_crc  = r_crc;
        n_hi   = r_hi;
        n_busy = 1'b0;
        if (r_busy) begin
            n_crc = fcs_nibble(r_crc, r_hi);
        end else if (i_seed_ld) begin
            n_crc = i_seed;
        end else if (i_byte_vld) begin
            // low digit now, park the high digit for the next cycle
            n_crc  = fcs_nibble(r_crc, i_byte[3:0]);
            n_hi   = i_byte[7:4];
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_busy <= n_busy;
        end
        r_hi <= n_hi;
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule

@@ rtl/sfr_pkt_buffer.sv @@
// ----------------------------------------------------------------------------
// sfr_pkt_buffer
// Packet store and the read-out stage that streams a verified packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_pkt_buffer
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 64
)(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_PACKET)-1:0]  i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  t_dlv_req                       i_dlv,
    output logic                           o_active,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [7:0]                     o_byte,
    output logic [LEN_W-1:0]               o_len,
    output logic                           o_last
);

    localparam int unsigned ADDR_W = $clog2(MAX_PACKET);

    logic [7:0]       r_mem [MAX_PACKET];
    logic [7:0]       r_rd_data;
    logic [ADDR_W-1:0] r_idx;
    logic [LEN_W-1:0] r_left;
    logic [LEN_W-1:0] r_len;
    logic             r_pend;
    logic             r_pend_last;
    logic [LEN_W-1:0] r_pend_len;
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_last;

    logic load, issue;

    // move read data to the output register when it is free or being taken
    assign load  = r_pend && (!r_out_vld || i_tready);
    assign issue = (r_left != '0) && (!r_pend || load);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_dlv.start) begin
                r_left <= i_dlv.len;
            end else if (issue) begin
                r_left <= r_left - 1'b1;
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dlv.start) begin
            r_idx <= '0;
            r_len <= i_dlv.len;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        if (issue) begin
            r_pend_last <= (r_left == LEN_W'(1));
            r_pend_len  <= r_len;
        end
        if (load) begin
            r_out_byte <= r_rd_data;
            r_out_len  <= r_pend_len;
            r_out_last <= r_pend_last;
        end
    end

    assign o_active = (r_left != '0) || r_pend;
    assign o_tvalid = r_out_vld;
    assign o_byte   = r_out_byte;
    assign o_len    = r_out_len;
    assign o_last   = r_out_last;

endmodule

@@ rtl/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic out_take;
    assign out_take = o_m_axis_tvalid && i_m_axis_tready;

    // a stalled packet byte holds
    property p_out_hold;
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast);
    endproperty

    // a delivered packet is never empty and the pad bit stays clear
    property p_len_valid;
        o_m_axis_tvalid |-> o_m_axis_tdata[14:8] != 7'd0 && !o_m_axis_tdata[15];
    endproperty

    // a byte right after a non-final byte belongs to the same packet
    property p_len_steady;
        out_take && !o_m_axis_tlast ##1 o_m_axis_tvalid |->
            o_m_axis_tdata[14:8] == $past(o_m_axis_tdata[14:8]);
    endproperty

    // nothing is offered in the cycle after reset
    property p_rst_quiet;
        !i_rst_n |=> !o_m_axis_tvalid;
    endproperty

    `SFR_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "packet byte changed while stalled")
    `SFR_ASSERT(a_len_valid, i_clk, i_rst_n, p_len_valid, "bad packet length on output")
    `SFR_ASSERT(a_len_steady, i_clk, i_rst_n, p_len_steady, "packet length changed in packet")
    `SFR_ASSERT_ALWAYS(a_rst_quiet, i_clk, p_rst_quiet, "output valid after reset")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
